/* src/opq_pkg.sv */
// opq_pkg: shared types and constants for the ordered process queue
// no dependencies; used by the interfaces, the engine, the top level and the checker
package opq_pkg;

  localparam int OP_BITS     = 2;
  localparam int POS_BITS    = 4;
  localparam int STATUS_BITS = 3;
  localparam int MODE_BITS   = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // operation codes carried by each input word
  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // status codes returned with each result word
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_REJECT = 3'd4
  } status_t;

  // ordering modes
  localparam logic [MODE_BITS-1:0] MODE_FIFO     = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_KEY_DESC = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_KEY_ASC  = 2'd2;

  // register index (byte address / 4)
  localparam logic [CFG_ADDR_W-3:0] REG_QUEUE_MODE = '0;

  // operation handed from the top level to the engine
  typedef struct packed {
    op_t                 op;
    logic                eligible;
    logic [POS_BITS-1:0] position;
  } cmd_t;

  // result flags handed back by the engine
  typedef struct packed {
    logic    rvalid;
    status_t status;
  } res_t;

endpackage

/* src/opq_if.sv */
// opq_in_if / opq_out_if: valid/ready channels of the ordered process queue
// depends on opq_pkg for field widths
interface opq_in_if #(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 8
);
  logic                         valid;
  logic                         ready;
  logic [opq_pkg::OP_BITS-1:0]  opcode;
  logic [KEY_BITS-1:0]          entry_key;
  logic [TAG_BITS-1:0]          entry_tag;
  logic                         eligible;
  logic [opq_pkg::POS_BITS-1:0] position;

  modport source (output valid, opcode, entry_key, entry_tag, eligible, position,
                  input ready);
  modport sink   (input valid, opcode, entry_key, entry_tag, eligible, position,
                  output ready);
endinterface

interface opq_out_if #(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 8,
  parameter int CNT_BITS = 5
);
  logic                            valid;
  logic                            ready;
  logic                            result_valid;
  logic [KEY_BITS-1:0]             result_key;
  logic [TAG_BITS-1:0]             result_tag;
  logic [CNT_BITS-1:0]             entry_total;
  logic [opq_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, result_valid, result_key, result_tag, entry_total, status,
                  input ready);
  modport sink   (input valid, result_valid, result_key, result_tag, entry_total, status,
                  output ready);
endinterface

/* src/opq_rank.sv */
// opq_rank: shared compare unit, tells whether a held entry ranks behind a new one
// depends on opq_pkg for the mode codes
module opq_rank #(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 8
) (
  input  logic [opq_pkg::MODE_BITS-1:0] mode,
  input  logic [KEY_BITS-1:0]           held_key,
  input  logic [TAG_BITS-1:0]           held_tag,
  input  logic [KEY_BITS-1:0]           new_key,
  input  logic [TAG_BITS-1:0]           new_tag,
  output logic                          behind
);

  // key compare, with tag tie-break in descending mode only; fifo and the unused code never rank behind
  always_comb begin
    case (mode)
      opq_pkg::MODE_KEY_DESC: behind = (held_key < new_key) ||
                                       ((held_key == new_key) && (held_tag < new_tag));
      opq_pkg::MODE_KEY_ASC:  behind = (held_key > new_key);
      default:                behind = 1'b0;
    endcase
  end

endmodule

/* src/opq_engine.sv */
// opq_engine: entry memory and the sequencer that walks it one entry per cycle
// depends on opq_pkg and opq_rank
module opq_engine #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_BITS    = 16,
  parameter int TAG_BITS    = 8,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  opq_pkg::cmd_t                 cmd,
  input  logic [KEY_BITS-1:0]           new_key,
  input  logic [TAG_BITS-1:0]           new_tag,
  input  logic [opq_pkg::MODE_BITS-1:0] mode,
  output logic                          idle,
  output logic                          res_valid,
  input  logic                          res_take,
  output opq_pkg::res_t                 res,
  output logic [KEY_BITS-1:0]           res_key,
  output logic [TAG_BITS-1:0]           res_tag,
  output logic [CW-1:0]                 res_count
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int EW    = KEY_BITS + TAG_BITS;
  localparam int CMP_W = (CW > opq_pkg::POS_BITS) ? CW : opq_pkg::POS_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_RM_HEAD,
    S_RM,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 placed_r, placed_nxt;
  logic [EW-1:0]        carry_r, carry_nxt;
  logic [EW-1:0]        nent_r, nent_nxt;
  opq_pkg::op_t         op_r, op_nxt;
  logic [KEY_BITS-1:0]  rkey_r, rkey_nxt;
  logic [TAG_BITS-1:0]  rtag_r, rtag_nxt;
  logic                 rvalid_r, rvalid_nxt;
  opq_pkg::status_t     status_r, status_nxt;

  logic [EW-1:0]        mem [QUEUE_DEPTH];
  logic [EW-1:0]        rd_data_r;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;

  logic [CW:0]          idx_p1, idx_p2, cnt_ext;
  logic [CMP_W-1:0]     pos_ext, cnt_cmp;
  logic                 behind;

  assign idx_p1  = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2  = {1'b0, idx_r} + (CW+1)'(2);
  assign cnt_ext = {1'b0, count_r};
  assign pos_ext = CMP_W'(cmd.position);
  assign cnt_cmp = CMP_W'(count_r);

  // shared compare unit, fed from the memory read register
  opq_rank #(
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_rank (
    .mode     (mode),
    .held_key (rd_data_r[EW-1:TAG_BITS]),
    .held_tag (rd_data_r[TAG_BITS-1:0]),
    .new_key  (nent_r[EW-1:TAG_BITS]),
    .new_tag  (nent_r[TAG_BITS-1:0]),
    .behind   (behind)
  );

  // sequencer next state and memory port control
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    placed_nxt = placed_r;
    carry_nxt  = carry_r;
    nent_nxt   = nent_r;
    op_nxt     = op_r;
    rkey_nxt   = rkey_r;
    rtag_nxt   = rtag_r;
    rvalid_nxt = rvalid_r;
    status_nxt = status_r;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = idx_r[AW-1:0];
    wr_data    = nent_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = cmd.op;
          nent_nxt   = {new_key, new_tag};
          rkey_nxt   = '0;
          rtag_nxt   = '0;
          rvalid_nxt = 1'b0;
          status_nxt = opq_pkg::ST_OK;
          placed_nxt = 1'b0;
          idx_nxt    = '0;
          case (cmd.op)
            opq_pkg::OP_INSERT: begin
              if (!cmd.eligible) begin
                status_nxt = opq_pkg::ST_REJECT;
                state_nxt  = S_DONE;
              end else if (count_r == CW'(QUEUE_DEPTH)) begin
                status_nxt = opq_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_INS;
              end
            end
            opq_pkg::OP_POP: begin
              if (count_r == '0) begin
                status_nxt = opq_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_RM_HEAD;
              end
            end
            default: begin
              if (pos_ext >= cnt_cmp) begin
                status_nxt = opq_pkg::ST_BADPOS;
                state_nxt  = S_DONE;
              end else begin
                rd_addr   = pos_ext[AW-1:0];
                idx_nxt   = pos_ext[CW-1:0];
                state_nxt = S_RM_HEAD;
              end
            end
          endcase
        end
      end
      // forward pass: place the new word before the first one that ranks behind,
      // then ripple the displaced words down by one
      S_INS: begin
        if (idx_r == count_r) begin
          wr_en     = 1'b1;
          wr_data   = placed_r ? carry_r : nent_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          if (idx_p1 < cnt_ext) begin
            rd_addr = idx_p1[AW-1:0];
          end
          if (placed_r) begin
            wr_en     = 1'b1;
            wr_data   = carry_r;
            carry_nxt = rd_data_r;
          end else if (behind) begin
            wr_en      = 1'b1;
            wr_data    = nent_r;
            carry_nxt  = rd_data_r;
            placed_nxt = 1'b1;
          end
          idx_nxt = idx_p1[CW-1:0];
        end
      end
      // capture the addressed word
      S_RM_HEAD: begin
        rkey_nxt   = rd_data_r[EW-1:TAG_BITS];
        rtag_nxt   = rd_data_r[TAG_BITS-1:0];
        rvalid_nxt = 1'b1;
        if (op_r == opq_pkg::OP_READ) begin
          state_nxt = S_DONE;
        end else if (idx_p1 == cnt_ext) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          rd_addr   = idx_p1[AW-1:0];
          state_nxt = S_RM;
        end
      end
      // close the gap one word per cycle
      S_RM: begin
        wr_en   = 1'b1;
        wr_data = rd_data_r;
        if (idx_p2 == cnt_ext) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          rd_addr = idx_p2[AW-1:0];
          idx_nxt = idx_p1[CW-1:0];
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r    <= idx_nxt;
    placed_r <= placed_nxt;
    carry_r  <= carry_nxt;
    nent_r   <= nent_nxt;
    op_r     <= op_nxt;
    rkey_r   <= rkey_nxt;
    rtag_r   <= rtag_nxt;
    rvalid_r <= rvalid_nxt;
    status_r <= status_nxt;
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = '{rvalid: rvalid_r, status: status_r};
  assign res_key   = rkey_r;
  assign res_tag   = rtag_r;
  assign res_count = count_r;

endmodule

/* src/ordered_process_queue.sv */
// ordered_process_queue: top level with configuration register and result register
// depends on opq_pkg, opq_if and opq_engine
//
// Bounded queue of (key, tag) words kept in fifo order, key descending with tag
// descending ties, or key ascending, chosen by the queue_mode register (byte address 0).
// Each input word is one operation (insert, pop, remove or read at a position) and gives
// exactly one result word with the entry concerned, the count held and a status. All work
// runs through one entry memory with one write and one registered read port, one entry per
// cycle, under a small sequencer, and the block takes one operation at a time: an insert
// makes a forward pass over every held entry, a remove or pop captures its entry and then
// shifts the later entries up to close the gap, a read only captures its entry, and a
// rejected operation goes straight to the result. A new word can be accepted while the
// previous result still waits in the output register.
module ordered_process_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_BITS    = 16,
  parameter int TAG_BITS    = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  opq_in_if.sink                             in_ch,
  opq_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [opq_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [opq_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [opq_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [opq_pkg::MODE_BITS-1:0] mode_r;
  logic                          cfg_wr;
  logic                          cfg_hit;

  opq_pkg::cmd_t                 cmd;
  logic                          start;
  logic                          eng_idle;
  logic                          eng_res_valid;
  logic                          res_take;
  opq_pkg::res_t                 eng_res;
  logic [KEY_BITS-1:0]           eng_key;
  logic [TAG_BITS-1:0]           eng_tag;
  logic [CW-1:0]                 eng_count;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_rvalid_r;
  logic [KEY_BITS-1:0]           out_key_r;
  logic [TAG_BITS-1:0]           out_tag_r;
  logic [CW-1:0]                 out_count_r;
  opq_pkg::status_t              out_status_r;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[opq_pkg::CFG_ADDR_W-1:2] == opq_pkg::REG_QUEUE_MODE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? {{(opq_pkg::CFG_DATA_W-opq_pkg::MODE_BITS){1'b0}}, mode_r}
                              : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= opq_pkg::MODE_FIFO;
    end else if (cfg_wr) begin
      mode_r <= cfg_pwdata[opq_pkg::MODE_BITS-1:0];
    end
  end

  // input word to the engine
  assign in_ch.ready  = eng_idle;
  assign start        = in_ch.valid && in_ch.ready;
  assign cmd.op       = opq_pkg::op_t'(in_ch.opcode);
  assign cmd.eligible = in_ch.eligible;
  assign cmd.position = in_ch.position;

  opq_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .TAG_BITS    (TAG_BITS),
    .CW          (CW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .new_key   (in_ch.entry_key),
    .new_tag   (in_ch.entry_tag),
    .mode      (mode_r),
    .idle      (eng_idle),
    .res_valid (eng_res_valid),
    .res_take  (res_take),
    .res       (eng_res),
    .res_key   (eng_key),
    .res_tag   (eng_tag),
    .res_count (eng_count)
  );

  // output register, loads whenever it is empty or being drained
  assign res_take = eng_res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_take) begin
      out_rvalid_r <= eng_res.rvalid;
      out_key_r    <= eng_key;
      out_tag_r    <= eng_tag;
      out_count_r  <= eng_count;
      out_status_r <= eng_res.status;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_valid = out_rvalid_r;
  assign out_ch.result_key   = out_key_r;
  assign out_ch.result_tag   = out_tag_r;
  assign out_ch.entry_total  = out_count_r;
  assign out_ch.status       = out_status_r;

endmodule

/* src/opq_checker.sv */
// opq_checker: port-level assertions for ordered_process_queue, bound to the top level
// depends on opq_pkg and ordered_process_queue
module opq_checker #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_BITS    = 16,
  parameter int TAG_BITS    = 8,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_result_valid,
  input logic [KEY_BITS-1:0]             out_result_key,
  input logic [TAG_BITS-1:0]             out_result_tag,
  input logic [CW-1:0]                   out_entry_total,
  input logic [opq_pkg::STATUS_BITS-1:0] out_status
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // one operation at a time: no new word right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an operation is in progress");

  // count never exceeds the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_total <= CW'(QUEUE_DEPTH)))
    else $error("entry count above queue depth");

  // an entry is only returned with ok status
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_valid |-> (out_status == opq_pkg::ST_OK))
    else $error("entry returned with failing status");

  // failed operations carry a cleared entry
  a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != opq_pkg::ST_OK) |->
      (!out_result_valid && (out_result_key == '0) && (out_result_tag == '0)))
    else $error("failed operation returned entry data");

endmodule

bind ordered_process_queue opq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .KEY_BITS    (KEY_BITS),
  .TAG_BITS    (TAG_BITS),
  .CW          (CW)
) u_opq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_valid (out_ch.result_valid),
  .out_result_key   (out_ch.result_key),
  .out_result_tag   (out_ch.result_tag),
  .out_entry_total  (out_ch.entry_total),
  .out_status       (out_ch.status)
);
